@@ hdl/kst_pkg.sv @@
`timescale 1ns / 1ps
// kst_pkg: shared command and status codes, memory word and result types
// used by the keyed score table; no dependencies
package kst_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_MAX    = 2'd2;
  localparam logic [1:0] CMD_SEARCH = 2'd3;

  localparam logic [1:0] ST_FAIL  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] score;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] best_key;
  } res_t;

endpackage

@@ hdl/keyed_score_table.sv @@
`timescale 1ns / 1ps
// keyed_score_table: top level with the command sequencer and result register
// depends on kst_pkg, kst_engine and kst_mem
//
// keyed score table: an unsorted, densely packed table of up to CAPACITY
// distinct 64-bit keys, each with a signed 16-bit score, held in one
// single-port-read synchronous memory. every command produces exactly one
// result transfer. insert (0) appends the key unless it is already present
// (status 0) or the table is full (status 3). delete (1) removes the key by
// moving the last entry into its slot. max (2) returns the key of the first
// entry in table order with the highest score, or status 2 on an empty
// table; best_key is zero for every other outcome. search (3) reports
// presence. each command scans the stored entries through the memory's
// one read port, which visits one slot per cycle; a key match ends the
// scan early, and a delete that moves the last entry adds a read of that
// entry and the write back into the hole. the next command is taken as
// soon as the sequencer has handed its result to the output register,
// even if that result is still waiting on out_ready. no clearing pass is
// needed after reset.
module keyed_score_table #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [63:0]        key,
  input  logic signed [15:0] score,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [63:0]        best_key
);
  import kst_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;

  // sequencer owns the table memory and the entry count
  kst_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .key       (key),
    .score     (score),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register is free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status   <= res.status;
      best_key <= res.best_key;
    end
  end

endmodule

@@ hdl/kst_mem.sv @@
`timescale 1ns / 1ps
// kst_mem: one-write one-read synchronous entry memory, registered read data
// depends on kst_pkg for the entry word type
module kst_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wen,
  input  logic [AW-1:0]   waddr,
  input  kst_pkg::entry_t wdata,
  input  logic            ren,
  input  logic [AW-1:0]   raddr,
  output kst_pkg::entry_t rdata
);
  import kst_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/kst_engine.sv @@
`timescale 1ns / 1ps
// kst_engine: command sequencer that scans the entry memory one slot per cycle
// depends on kst_pkg and kst_mem
module kst_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [63:0]                key,
  input  logic signed [15:0]         score,
  output logic                       res_valid,
  input  logic                       res_ready,
  output kst_pkg::res_t              res
);
  import kst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]         state;
  logic [1:0]         cmd;
  logic [63:0]        key_q;
  logic signed [15:0] score_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      issue_idx;
  logic               pend_valid;
  logic [AW-1:0]      pend_idx;
  logic [AW-1:0]      hole;
  logic               best_valid;
  logic signed [15:0] best_score;
  logic [63:0]        best_key_q;
  logic [1:0]         status_q;

  logic          mem_wen;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_ren;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic          hit;
  logic          more;
  logic          improve;
  logic          scan_end;
  logic [CW-1:0] last_idx;

  kst_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign last_idx = count - CW'(1);
  assign more     = (issue_idx != count);
  assign hit      = pend_valid && (cmd != CMD_MAX) && (mem_rdata.key == key_q);
  assign improve  = pend_valid && (!best_valid || (mem_rdata.score > best_score));
  assign scan_end = hit || (!more && !pend_valid);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res.status   = status_q;
  assign res.best_key = best_key_q;

  // memory port control
  always_comb begin
    mem_ren   = 1'b0;
    mem_raddr = issue_idx[AW-1:0];
    mem_wen   = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = '{key: key_q, score: score_q};
    unique case (state)
      S_SCAN: begin
        mem_ren = more && !hit;
        if (scan_end && !hit && cmd == CMD_INSERT && count != CAP) begin
          mem_wen = 1'b1;
        end
      end
      S_LAST: begin
        mem_ren   = 1'b1;
        mem_raddr = last_idx[AW-1:0];
      end
      S_MOVE: begin
        mem_wen   = 1'b1;
        mem_waddr = hole;
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            key_q      <= key;
            score_q    <= score;
            issue_idx  <= '0;
            pend_valid <= 1'b0;
            best_valid <= 1'b0;
            best_key_q <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_valid <= mem_ren;
          pend_idx   <= issue_idx[AW-1:0];
          if (mem_ren) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (cmd == CMD_MAX && improve) begin
            best_valid <= 1'b1;
            best_score <= mem_rdata.score;
            best_key_q <= mem_rdata.key;
          end
          if (scan_end) begin
            pend_valid <= 1'b0;
            state      <= S_RESP;
            unique case (cmd)
              CMD_INSERT: begin
                if (hit) begin
                  status_q <= ST_FAIL;
                end else if (count == CAP) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  count    <= count + CW'(1);
                end
              end
              CMD_DELETE: begin
                if (!hit) begin
                  status_q <= ST_FAIL;
                end else if (pend_idx == last_idx[AW-1:0]) begin
                  status_q <= ST_OK;
                  count    <= last_idx;
                end else begin
                  hole  <= pend_idx;
                  state <= S_LAST;
                end
              end
              CMD_MAX: begin
                status_q <= (count == '0) ? ST_EMPTY : ST_OK;
              end
              CMD_SEARCH: begin
                status_q <= hit ? ST_OK : ST_FAIL;
              end
              default: begin
                status_q <= ST_FAIL;
              end
            endcase
          end
        end
        S_LAST: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          status_q <= ST_OK;
          count    <= last_idx;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_keyed_score_table.sv @@
`timescale 1ns / 1ps
// tb_keyed_score_table: self-checking testbench for the keyed score table,
// with a clocked driver, a clocked monitor and a table predictor
// depends on kst_pkg and keyed_score_table
module tb_keyed_score_table;
  import kst_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 850;
  // receiver hold-off: starts once this many commands have gone in
  localparam int HOLD_AT      = 150;
  localparam int HOLD_LEN     = 600;
  // settle time after the last result, well past one full-table scan
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_PRINTS   = 50;

  typedef struct {
    logic [1:0]         cmd;
    logic [63:0]        key;
    logic signed [15:0] score;
  } table_cmd_t;

  // shape of a stretch of random commands
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = CMD_INSERT;
  logic [63:0]        key = '0;
  logic signed [15:0] score = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [63:0]        best_key;

  // commands waiting to be offered, and results still owed by the block
  table_cmd_t pending_cmds[$];
  res_t       expected_results[$];

  // keys that the generator believes present, so that it can aim at hits
  logic [63:0] gen_live[$];

  // predictor copy of the table, touched only by the driver process
  logic [63:0]        tbl_key[TABLE_DEPTH];
  logic signed [15:0] tbl_score[TABLE_DEPTH];
  int                 tbl_count = 0;

  int total_items = 0;
  int sent_count = 0;
  int results_seen = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int send_idle_pct;
  int recv_idle_pct;

  keyed_score_table #(
    .CAPACITY (TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .key       (key),
    .score     (score),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .best_key  (best_key)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one line per mismatch, counted; printing stops after a while
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTS)
      $display("mismatch on result %0d: %s got %h expected %h",
               results_seen, what, got, want);
    error_count++;
  endtask

  // apply one command to the predictor table and return its result
  function automatic res_t apply_table_command(input logic [1:0] cmd,
                                               input logic [63:0] k,
                                               input logic signed [15:0] s);
    res_t r;
    int   slot;
    int   win;
    r.status   = ST_FAIL;
    r.best_key = '0;
    // linear scan from the last entry down; tbl_count means absent
    slot = tbl_count;
    for (int i = tbl_count - 1; i >= 0; i--)
      if (tbl_key[i] == k) slot = i;
    case (cmd)
      CMD_INSERT: begin
        if (slot < tbl_count) begin
          r.status = ST_FAIL;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_key[tbl_count]   = k;
          tbl_score[tbl_count] = s;
          tbl_count++;
          r.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        // last entry moves into the freed slot
        if (slot < tbl_count) begin
          tbl_key[slot]   = tbl_key[tbl_count - 1];
          tbl_score[slot] = tbl_score[tbl_count - 1];
          tbl_count--;
          r.status = ST_OK;
        end
      end
      CMD_MAX: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // strict compare keeps the lowest slot on a tie
          win = 0;
          for (int i = 1; i < tbl_count; i++)
            if (tbl_score[i] > tbl_score[win]) win = i;
          r.best_key = tbl_key[win];
          r.status   = ST_OK;
        end
      end
      default: begin
        r.status = (slot < tbl_count) ? ST_OK : ST_FAIL;
      end
    endcase
    return r;
  endfunction

  // queue a command and track what the table should hold afterwards
  task automatic queue_command(input logic [1:0] cmd, input logic [63:0] k,
                               input logic signed [15:0] s);
    table_cmd_t c;
    int         idx;
    c.cmd   = cmd;
    c.key   = k;
    c.score = s;
    pending_cmds.push_back(c);
    idx = -1;
    foreach (gen_live[i])
      if (gen_live[i] == k) idx = i;
    if (cmd == CMD_INSERT && idx < 0 && gen_live.size() < TABLE_DEPTH)
      gen_live.push_back(k);
    else if (cmd == CMD_DELETE && idx >= 0)
      gen_live.delete(idx);
  endtask

  // a present key with the given odds, else an extreme or a fresh key
  function automatic logic [63:0] choose_key(input int live_pct);
    int roll;
    roll = $urandom_range(99);
    if (gen_live.size() > 0 && roll < live_pct)
      return gen_live[$urandom_range(gen_live.size() - 1)];
    if (roll >= 95)
      return ($urandom_range(1) != 0) ? '1 : '0;
    return {$urandom, $urandom};
  endfunction

  // narrow scores make ties common; the rest spans the whole range
  function automatic logic signed [15:0] choose_score();
    int roll;
    int v;
    roll = $urandom_range(99);
    v = $urandom_range(6);
    if (roll < 40) return 16'(v - 3);
    if (roll < 45) return 16'sh8000;
    if (roll < 50) return 16'sh7fff;
    return 16'($urandom_range(16'hffff));
  endfunction

  // idling phases follow how far the stimulus has got
  always_comb begin
    if (sent_count < total_items / 3) begin
      send_idle_pct = 7;
      recv_idle_pct = 64;
    end else if (sent_count < (2 * total_items) / 3) begin
      send_idle_pct = 64;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // driver: predicts on each input transfer, then offers the next command
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tbl_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_table_command(command, key, score));
        sent_count <= sent_count + 1;
      end
      // payload only changes once the current offer is gone
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          command  <= pending_cmds[0].cmd;
          key      <= pending_cmds[0].key;
          score    <= pending_cmds[0].score;
          pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, so the block backs up and drops in_ready
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, status", 64'(status), '0);
        end else begin
          if (status !== expected_results[0].status)
            report_mismatch("status", 64'(status), 64'(expected_results[0].status));
          if (best_key !== expected_results[0].best_key)
            report_mismatch("best_key", best_key, expected_results[0].best_key);
          expected_results.pop_front();
        end
        results_seen++;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    logic [63:0] mid_key;
    seg_mode_t   mode;
    int          seg_len;
    int          roll;
    int          target;
    logic [1:0]  cmd;
    bit          first_seg;

    mid_key = {$urandom, $urandom};

    // directed: empty table, extreme keys and scores, duplicates, ties,
    // and deletes that pull the last entry into the hole
    queue_command(CMD_MAX, '0, '0);
    queue_command(CMD_SEARCH, '0, '0);
    queue_command(CMD_DELETE, '0, '0);
    queue_command(CMD_INSERT, '0, 16'sh8000);
    queue_command(CMD_INSERT, '1, 16'sh7fff);
    queue_command(CMD_INSERT, '0, 16'sd5);
    queue_command(CMD_MAX, '0, '0);
    queue_command(CMD_SEARCH, '1, '0);
    queue_command(CMD_INSERT, mid_key, 16'sh7fff);
    queue_command(CMD_MAX, '1, 16'sh7fff);
    queue_command(CMD_DELETE, '0, 16'sh8000);
    queue_command(CMD_MAX, '0, '0);
    queue_command(CMD_DELETE, mid_key, '0);
    queue_command(CMD_SEARCH, mid_key, '0);
    queue_command(CMD_DELETE, '1, '0);
    queue_command(CMD_SEARCH, '1, '1);
    queue_command(CMD_MAX, '1, '1);
    queue_command(CMD_INSERT, 64'h5555_aaaa_5555_aaaa, -16'sd1);
    queue_command(CMD_INSERT, 64'haaaa_5555_aaaa_5555, -16'sd1);
    queue_command(CMD_MAX, 64'h1234_5678_9abc_def0, '0);
    queue_command(CMD_DELETE, 64'h0123_4567_89ab_cdef, '0);
    queue_command(CMD_SEARCH, 64'haaaa_5555_aaaa_5555, '0);

    // random: stretches that fill, drain or mix, the first one a fill
    // long enough to reach a full table
    target = pending_cmds.size() + RANDOM_ITEMS;
    first_seg = 1'b1;
    while (pending_cmds.size() < target) begin
      mode    = first_seg ? SEG_FILL : seg_mode_t'($urandom_range(2));
      seg_len = first_seg ? 110 : $urandom_range(40, 110);
      first_seg = 1'b0;
      for (int j = 0; j < seg_len && pending_cmds.size() < target; j++) begin
        roll = $urandom_range(99);
        case (mode)
          SEG_FILL: begin
            cmd = (roll < 85) ? CMD_INSERT : (roll < 90) ? CMD_DELETE :
                  (roll < 95) ? CMD_MAX : CMD_SEARCH;
          end
          SEG_DRAIN: begin
            cmd = (roll < 60) ? CMD_DELETE : (roll < 70) ? CMD_INSERT :
                  (roll < 85) ? CMD_MAX : CMD_SEARCH;
          end
          default: begin
            cmd = 2'($urandom_range(3));
          end
        endcase
        if (mode == SEG_FILL && cmd == CMD_INSERT)
          queue_command(cmd, choose_key(15), choose_score());
        else
          queue_command(cmd, choose_key(60), choose_score());
      end
    end
    total_items = pending_cmds.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // wait for every command to go in and every result to come back
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    foreach (expected_results[i])
      report_mismatch("missing result, status", '0, 64'(expected_results[i].status));

    if (error_count == 0) begin
      $display("tb_keyed_score_table: PASS");
    end else begin
      $display("tb_keyed_score_table: FAIL");
    end
    $finish;
  end

  // watchdog: many times the slowest expected run
  initial begin
    #10_000_000;
    $display("tb_keyed_score_table: FAIL");
    $finish;
  end

endmodule
